// ===== sv/mcf_pkg.sv =====
// Shared types, command codes and frame constants for the MP3 module command framer.
// No dependencies; used by every module of the framer.
package mcf_pkg;

	// Input command kinds
	typedef enum logic [2:0] {
		KIND_PLAY     = 3'd0,
		KIND_STOP     = 3'd1,
		KIND_SET_VOL  = 3'd2,
		KIND_VOL_UP   = 3'd3,
		KIND_VOL_DOWN = 3'd4
	} kind_t;

	// Player command codes
	localparam logic [7:0] CMD_PLAY     = 8'h03;
	localparam logic [7:0] CMD_STOP     = 8'h0E;
	localparam logic [7:0] CMD_SET_VOL  = 8'h06;
	localparam logic [7:0] CMD_VOL_UP   = 8'h04;
	localparam logic [7:0] CMD_VOL_DOWN = 8'h05;

	// Frame bytes
	localparam logic [7:0] FRAME_START   = 8'h7E;
	localparam logic [7:0] FRAME_VERSION = 8'hFF;
	localparam logic [7:0] FRAME_END     = 8'hEF;
	localparam logic [7:0] LEN_SHORT     = 8'h04;
	localparam logic [7:0] LEN_LONG      = 8'h06;
	localparam logic [7:0] FEEDBACK_OFF  = 8'h00;

	localparam logic [4:0] VOLUME_MAX   = 5'd30;
	localparam logic [4:0] VOLUME_RESET = 5'd8;

	// Byte positions within the long frame layout; short frames skip PH/PL
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_START = 4'd0;
	localparam logic [POS_W-1:0] POS_VER   = 4'd1;
	localparam logic [POS_W-1:0] POS_LEN   = 4'd2;
	localparam logic [POS_W-1:0] POS_CMD   = 4'd3;
	localparam logic [POS_W-1:0] POS_FB    = 4'd4;
	localparam logic [POS_W-1:0] POS_PH    = 4'd5;
	localparam logic [POS_W-1:0] POS_PL    = 4'd6;
	localparam logic [POS_W-1:0] POS_CKH   = 4'd7;
	localparam logic [POS_W-1:0] POS_CKL   = 4'd8;
	localparam logic [POS_W-1:0] POS_END   = 4'd9;
	localparam logic [POS_W-1:0] PARAM_SKIP = 4'd2;

	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified command, ready to serialize
	typedef struct packed {
		logic [7:0]  cmd;
		logic        is_long;
		logic [7:0]  param;
		logic [15:0] ck;
		logic [4:0]  volume;
	} desc_t;

	// Frame byte at a long-layout position
	function automatic logic [7:0] byte_at(desc_t d, logic [POS_W-1:0] pos);
		logic [7:0] b;
		b = FRAME_END;
		unique case (pos)
			POS_START: b = FRAME_START;
			POS_VER:   b = FRAME_VERSION;
			POS_LEN:   b = d.is_long ? LEN_LONG : LEN_SHORT;
			POS_CMD:   b = d.cmd;
			POS_FB:    b = FEEDBACK_OFF;
			POS_PH:    b = 8'h00;
			POS_PL:    b = d.param;
			POS_CKH:   b = d.ck[15:8];
			POS_CKL:   b = d.ck[7:0];
			default:   b = FRAME_END;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/mcf_front.sv =====
// Front end of the command framer: accepts commands, tracks volume, builds frame descriptors.
// Depends on mcf_pkg.
module mcf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         kind,
	input  logic [7:0]         track_number,
	input  logic [4:0]         new_volume,
	input  logic               q_full,
	output logic               push,
	output mcf_pkg::desc_t     push_desc
);

	logic       accept;
	logic       keep;
	logic [4:0] vol_next;
	logic [15:0] sum;
	logic [4:0] volume_q;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !q_full;

	// Classify the command and work out the new volume
	always_comb begin
		keep              = 1'b0;
		vol_next          = volume_q;
		push_desc.cmd     = mcf_pkg::CMD_STOP;
		push_desc.is_long = 1'b0;
		push_desc.param   = 8'h00;
		unique case (mcf_pkg::kind_t'(kind))
			mcf_pkg::KIND_PLAY: begin
				keep              = 1'b1;
				push_desc.cmd     = mcf_pkg::CMD_PLAY;
				push_desc.is_long = 1'b1;
				push_desc.param   = track_number;
			end
			mcf_pkg::KIND_STOP: begin
				keep          = 1'b1;
				push_desc.cmd = mcf_pkg::CMD_STOP;
			end
			mcf_pkg::KIND_SET_VOL: begin
				keep              = (new_volume <= mcf_pkg::VOLUME_MAX);
				vol_next          = keep ? new_volume : volume_q;
				push_desc.cmd     = mcf_pkg::CMD_SET_VOL;
				push_desc.is_long = 1'b1;
				push_desc.param   = {3'b000, new_volume};
			end
			mcf_pkg::KIND_VOL_UP: begin
				keep          = (volume_q < mcf_pkg::VOLUME_MAX);
				vol_next      = keep ? volume_q + 5'd1 : volume_q;
				push_desc.cmd = mcf_pkg::CMD_VOL_UP;
			end
			mcf_pkg::KIND_VOL_DOWN: begin
				keep          = (volume_q != 5'd0);
				vol_next      = keep ? volume_q - 5'd1 : volume_q;
				push_desc.cmd = mcf_pkg::CMD_VOL_DOWN;
			end
			default: keep = 1'b0;
		endcase
		// checksum: negated sum of version, length, cmd and parameter bytes
		sum = 16'(mcf_pkg::FRAME_VERSION)
			+ 16'(push_desc.is_long ? mcf_pkg::LEN_LONG : mcf_pkg::LEN_SHORT)
			+ 16'(push_desc.cmd) + 16'(push_desc.param);
		push_desc.ck     = 16'd0 - sum;
		push_desc.volume = vol_next;
	end

	assign push = accept && keep;

	// Volume register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= mcf_pkg::VOLUME_RESET;
		end else if (accept) begin
			volume_q <= vol_next;
		end
	end

endmodule

// ===== sv/mcf_queue.sv =====
// Short descriptor queue between front and back of the command framer.
// Depends on mcf_pkg.
module mcf_queue #(
	parameter int unsigned Depth = mcf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcf_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output mcf_pkg::desc_t pop_desc,
	output logic           empty
);

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LAST = AW'(Depth - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

	mcf_pkg::desc_t mem_q [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_desc = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/mcf_back.sv =====
// Back end of the command framer: serializes one descriptor into frame bytes.
// Depends on mcf_pkg.
module mcf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  mcf_pkg::desc_t pop_desc,
	output logic           pop,
	output logic           frame_valid,
	input  logic           frame_stall,
	output logic [7:0]     frame_byte,
	output logic           last_byte,
	output logic [4:0]     current_volume
);

	logic                        active_q;
	mcf_pkg::desc_t              desc_q;
	logic [mcf_pkg::POS_W-1:0]   idx_q;
	logic                        frame_valid_q;
	logic [7:0]                  frame_byte_q;
	logic                        last_byte_q;
	logic [4:0]                  current_volume_q;

	logic                        adv;
	logic                        emit;
	logic [mcf_pkg::POS_W-1:0]   pos;
	logic                        at_end;

	// Map the byte counter onto the long layout; short frames skip PH/PL
	assign pos    = (desc_q.is_long || idx_q < mcf_pkg::POS_PH)
	                ? idx_q : idx_q + mcf_pkg::PARAM_SKIP;
	assign at_end = (pos == mcf_pkg::POS_END);
	assign adv    = !frame_valid_q || !frame_stall;
	assign emit   = adv && active_q;
	assign pop    = !empty && (!active_q || (emit && at_end));

	// Serializer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (emit) begin
			if (at_end) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + mcf_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_desc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (adv) begin
			frame_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_byte_q     <= mcf_pkg::byte_at(desc_q, pos);
			last_byte_q      <= at_end;
			current_volume_q <= desc_q.volume;
		end
	end

	assign frame_valid    = frame_valid_q;
	assign frame_byte     = frame_byte_q;
	assign last_byte      = last_byte_q;
	assign current_volume = current_volume_q;

endmodule

// ===== sv/mp3_module_command_framer.sv =====
// Top level of the MP3 module command framer: front end, descriptor queue, byte serializer.
// Depends on mcf_pkg, mcf_front, mcf_queue and mcf_back.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------------------------
//   cmd     | cmd_valid   | cmd_stall   | kind, track_number, new_volume
//   frame   | frame_valid | frame_stall | frame_byte, last_byte, current_volume
//
// A command is taken and yields 8 (short) or 10 (long) frame words, one per cycle while frame_stall
// is low; the byte serializer sets the rate and takes the next descriptor as a frame's last word goes out.
// The descriptor queue lets up to QueueDepth further commands be taken while a frame drains.
// Rejected or unknown commands produce no words. Reset sets volume to 8 and empties all.
// A stall on the frame side holds the output word; the front stalls only when the queue is full.
module mp3_module_command_framer #(
	parameter int unsigned QueueDepth = mcf_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] kind,
	input  logic [7:0] track_number,
	input  logic [4:0] new_volume,
	output logic       frame_valid,
	input  logic       frame_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte,
	output logic [4:0] current_volume
);

	logic           push, pop, q_full, q_empty;
	mcf_pkg::desc_t push_desc, pop_desc;

	mcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.kind         (kind),
		.track_number (track_number),
		.new_volume   (new_volume),
		.q_full       (q_full),
		.push         (push),
		.push_desc    (push_desc)
	);

	mcf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.empty     (q_empty)
	);

	mcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (q_empty),
		.pop_desc       (pop_desc),
		.pop            (pop),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.current_volume (current_volume)
	);

endmodule

// ===== verif/mcf_checker.sv =====
// Checker for the MP3 module command framer: watches the command and frame channels,
// predicts the frame words for every accepted command and compares them in order.
// Depends on mcf_pkg for command kinds, command codes and frame constants.
module mcf_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_stall,
	input  logic [2:0] kind,
	input  logic [7:0] track_number,
	input  logic [4:0] new_volume,
	input  logic       frame_valid,
	input  logic       frame_stall,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	input  logic [4:0] current_volume,
	output int         fail_count,
	output int         words_pending,
	output int         words_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [4:0] volume;
	} frame_word_t;

	frame_word_t words_due[$];
	logic [4:0]  volume_now;
	int          fails;
	int          checked;

	// queue one predicted word, tagged with the volume after the command
	task automatic queue_word(input logic [7:0] data, input logic last);
		frame_word_t w;
		w.data   = data;
		w.last   = last;
		w.volume = volume_now;
		words_due.push_back(w);
	endtask

	// short or long frame with its 16-bit negated checksum
	task automatic queue_frame(input logic [7:0] cmd, input logic is_long, input logic [7:0] param);
		logic [7:0]  len;
		logic [15:0] sum;
		logic [15:0] ck;
		len = is_long ? mcf_pkg::LEN_LONG : mcf_pkg::LEN_SHORT;
		sum = {8'h00, mcf_pkg::FRAME_VERSION} + {8'h00, len} + {8'h00, cmd};
		queue_word(mcf_pkg::FRAME_START, 1'b0);
		queue_word(mcf_pkg::FRAME_VERSION, 1'b0);
		queue_word(len, 1'b0);
		queue_word(cmd, 1'b0);
		queue_word(mcf_pkg::FEEDBACK_OFF, 1'b0);
		if (is_long) begin
			queue_word(8'h00, 1'b0);
			queue_word(param, 1'b0);
			sum = sum + {8'h00, param};
		end
		ck = 16'h0000 - sum;
		queue_word(ck[15:8], 1'b0);
		queue_word(ck[7:0], 1'b0);
		queue_word(mcf_pkg::FRAME_END, 1'b1);
	endtask

	// apply one command to the volume and queue its frame; rejects queue nothing
	task automatic predict_command(input logic [2:0] k, input logic [7:0] track,
			input logic [4:0] vol);
		case (k)
			mcf_pkg::KIND_PLAY: begin
				queue_frame(mcf_pkg::CMD_PLAY, 1'b1, track);
			end
			mcf_pkg::KIND_STOP: begin
				queue_frame(mcf_pkg::CMD_STOP, 1'b0, 8'h00);
			end
			mcf_pkg::KIND_SET_VOL: begin
				if (vol <= mcf_pkg::VOLUME_MAX) begin
					volume_now = vol;
					queue_frame(mcf_pkg::CMD_SET_VOL, 1'b1, {3'b000, vol});
				end
			end
			mcf_pkg::KIND_VOL_UP: begin
				if (volume_now < mcf_pkg::VOLUME_MAX) begin
					volume_now = volume_now + 5'd1;
					queue_frame(mcf_pkg::CMD_VOL_UP, 1'b0, 8'h00);
				end
			end
			mcf_pkg::KIND_VOL_DOWN: begin
				if (volume_now != 5'd0) begin
					volume_now = volume_now - 5'd1;
					queue_frame(mcf_pkg::CMD_VOL_DOWN, 1'b0, 8'h00);
				end
			end
			default: begin
			end
		endcase
	endtask

	// predict on accepted commands, then check accepted frame words in order
	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			volume_now = mcf_pkg::VOLUME_RESET;
			words_due.delete();
			fails   = 0;
			checked = 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				predict_command(kind, track_number, new_volume);
			if (frame_valid && !frame_stall) begin
				if (words_due.size() == 0) begin
					$display("%0t: unexpected frame word %h last %b volume %0d", $time,
						frame_byte, last_byte, current_volume);
					fails++;
				end else begin
					want = words_due.pop_front();
					checked++;
					if (frame_byte !== want.data) begin
						$display("%0t: frame_byte expected %h actual %h", $time,
							want.data, frame_byte);
						fails++;
					end
					if (last_byte !== want.last) begin
						$display("%0t: last_byte expected %b actual %b", $time,
							want.last, last_byte);
						fails++;
					end
					if (current_volume !== want.volume) begin
						$display("%0t: current_volume expected %0d actual %0d", $time,
							want.volume, current_volume);
						fails++;
					end
				end
			end
		end
		fail_count    <= fails;
		words_pending <= words_due.size();
		words_checked <= checked;
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the MP3 module command framer: clock, reset, command stimulus,
// random frame stalls, watchdog and verdict. Depends on mcf_pkg, mcf_checker and the framer.
module tb_top;

	localparam int          IDLE_LIMIT        = 5000;
	localparam int          PHASE_ITEMS       = 67;
	localparam int          DRAIN_CYCLES      = 20;
	localparam logic [2:0]  KIND_FIRST_UNUSED = 3'd5;
	localparam logic [2:0]  KIND_LAST_UNUSED  = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [2:0] kind;
	logic [7:0] track_number;
	logic [4:0] new_volume;
	logic       frame_valid;
	logic       frame_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       last_byte;
	logic [4:0] current_volume;

	int fail_count;
	int words_pending;
	int words_checked;
	int tx_idle_pct;
	int rx_idle_pct;
	int idle_cycles;
	int cmds_sent;

	mp3_module_command_framer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.kind           (kind),
		.track_number   (track_number),
		.new_volume     (new_volume),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.current_volume (current_volume)
	);

	mcf_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.kind           (kind),
		.track_number   (track_number),
		.new_volume     (new_volume),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.current_volume (current_volume),
		.fail_count     (fail_count),
		.words_pending  (words_pending),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		frame_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (frame_valid && !frame_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// present one command after a random gap and hold it until accepted
	task automatic send_cmd(input logic [2:0] k, input logic [7:0] track, input logic [4:0] vol);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid    <= 1'b1;
		kind         <= k;
		track_number <= track;
		new_volume   <= vol;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		cmds_sent++;
	endtask

	// drop valid and hold off until every predicted word has arrived
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
	endtask

	// mostly legal commands, some rejects and unused kinds; unused kinds are not counted
	task automatic send_random(output int counted);
		int         pick;
		logic [4:0] vol;
		pick    = $urandom_range(0, 99);
		counted = 1;
		vol     = 5'($urandom_range(0, 31));
		if (pick < 25) begin
			send_cmd(mcf_pkg::KIND_PLAY, 8'($urandom_range(0, 255)), vol);
		end else if (pick < 35) begin
			send_cmd(mcf_pkg::KIND_STOP, 8'($urandom_range(0, 255)), vol);
		end else if (pick < 55) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: vol = 5'd0;
					1: vol = 5'd1;
					2: vol = mcf_pkg::VOLUME_MAX - 5'd1;
					3: vol = mcf_pkg::VOLUME_MAX;
					default: vol = mcf_pkg::VOLUME_MAX + 5'd1;
				endcase
			end else begin
				vol = 5'($urandom_range(0, mcf_pkg::VOLUME_MAX));
			end
			send_cmd(mcf_pkg::KIND_SET_VOL, 8'($urandom_range(0, 255)), vol);
		end else if (pick < 75) begin
			send_cmd(mcf_pkg::KIND_VOL_UP, 8'($urandom_range(0, 255)), vol);
		end else if (pick < 95) begin
			send_cmd(mcf_pkg::KIND_VOL_DOWN, 8'($urandom_range(0, 255)), vol);
		end else begin
			send_cmd(3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED)),
				8'($urandom_range(0, 255)), vol);
			counted = 0;
		end
	endtask

	initial begin
		int sent;
		int counted;
		cmd_valid    <= 1'b0;
		kind         <= mcf_pkg::KIND_STOP;
		track_number <= 8'h00;
		new_volume   <= 5'd0;
		arst_n       <= 1'b0;
		idle_cycles  = 0;
		cmds_sent    = 0;
		tx_idle_pct  = 11;
		rx_idle_pct  = 86;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: track extremes, every kind, volume limits and rejects
		send_cmd(mcf_pkg::KIND_VOL_UP, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_PLAY, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_PLAY, 8'hFF, 5'd31);
		send_cmd(mcf_pkg::KIND_PLAY, 8'hAA, 5'd10);
		send_cmd(mcf_pkg::KIND_PLAY, 8'h55, 5'd21);
		send_cmd(mcf_pkg::KIND_STOP, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_VOL_DOWN, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_VOL_UP, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'hFF, mcf_pkg::VOLUME_MAX);
		send_cmd(mcf_pkg::KIND_VOL_UP, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_VOL_DOWN, 8'h00, 5'd0);
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'h00, mcf_pkg::VOLUME_MAX + 5'd1);
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'h00, 5'd21);
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'h00, 5'd10);
		send_cmd(mcf_pkg::KIND_PLAY, 8'h01, 5'd31);
		for (int u = KIND_FIRST_UNUSED; u <= KIND_LAST_UNUSED; u++)
			send_cmd(u[2:0], 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
		send_cmd(mcf_pkg::KIND_SET_VOL, 8'h80, mcf_pkg::VOLUME_RESET);
		wait_drained();

		// random: three mixes of sender gaps and receiver stalls
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 86;
				end
				1: begin
					tx_idle_pct = 86;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 19) == 0)
					wait_drained();
				send_random(counted);
				sent += counted;
			end
			wait_drained();
		end

		// trailing quiet time for anything the block might still emit
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d commands over three gap/stall mixes; %0d frame words checked",
			cmds_sent, words_checked);
		if (fail_count == 0 && words_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
